### rtl/smx_pkg.sv
package smx_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int CONST_DEPTH = 128;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CAW = $clog2(CONST_DEPTH);
  localparam int CNTW = SAW + 1;

  localparam logic [4:0] OP_OPEN     = 5'd0;
  localparam logic [4:0] OP_CLOSE    = 5'd1;
  localparam logic [4:0] OP_RSVCONST = 5'd2;
  localparam logic [4:0] OP_RSVVAR   = 5'd3;
  localparam logic [4:0] OP_PUSH     = 5'd4;
  localparam logic [4:0] OP_LOAD     = 5'd5;
  localparam logic [4:0] OP_STORE    = 5'd6;
  localparam logic [4:0] OP_READIN   = 5'd7;
  localparam logic [4:0] OP_WRITE    = 5'd8;
  localparam logic [4:0] OP_WRITELN  = 5'd9;
  localparam logic [4:0] OP_ADD      = 5'd10;
  localparam logic [4:0] OP_SUB      = 5'd11;
  localparam logic [4:0] OP_MUL      = 5'd12;
  localparam logic [4:0] OP_DIV      = 5'd13;
  localparam logic [4:0] OP_MOD      = 5'd14;
  localparam logic [4:0] OP_POW      = 5'd15;
  localparam logic [4:0] OP_ABS      = 5'd16;
  localparam logic [4:0] OP_NEG      = 5'd17;
  localparam logic [4:0] OP_EQ       = 5'd18;
  localparam logic [4:0] OP_NE       = 5'd19;
  localparam logic [4:0] OP_LT       = 5'd20;
  localparam logic [4:0] OP_GT       = 5'd21;
  localparam logic [4:0] OP_LE       = 5'd22;
  localparam logic [4:0] OP_GE       = 5'd23;
  localparam logic [4:0] OP_OR       = 5'd24;
  localparam logic [4:0] OP_AND      = 5'd25;
  localparam logic [4:0] OP_NOT      = 5'd26;
  localparam logic [4:0] OP_BFALSE   = 5'd27;
  localparam logic [4:0] OP_BTRUE    = 5'd28;
  localparam logic [4:0] OP_BRA      = 5'd29;
  localparam logic [4:0] OP_NOP      = 5'd30;
  localparam logic [4:0] OP_SETCONST = 5'd31;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_OVF   = 3'd1;
  localparam logic [2:0] ERR_UNF   = 3'd2;
  localparam logic [2:0] ERR_ADDR  = 3'd3;
  localparam logic [2:0] ERR_DIV0  = 3'd4;
  localparam logic [2:0] ERR_MOD0  = 3'd5;

  // request to the sequential arithmetic unit
  typedef struct packed {
    logic        start;
    logic [1:0]  kind;   // 0 mul, 1 div, 2 mod, 3 pow
    logic [31:0] a;
    logic [31:0] b;
  } smx_ar_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } smx_ar_rsp_t;

  localparam logic [1:0] AK_MUL = 2'd0;
  localparam logic [1:0] AK_DIV = 2'd1;
  localparam logic [1:0] AK_MOD = 2'd2;
  localparam logic [1:0] AK_POW = 2'd3;

endpackage

### rtl/smx_ram.sv
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/smx_arith.sv
module smx_arith import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  smx_ar_req_t req,
  output smx_ar_rsp_t rsp
);

  // one radix-2 step per cycle: shift-add multiply, restoring divide,
  // square-and-multiply power (a multiply if the bit is set and a squaring per exponent bit)
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_POW  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [1:0]  kind_r;
  logic [5:0]  cnt_r;
  logic [31:0] x_r, y_r, acc_r, rem_r;
  logic        neg_r;
  // power: result, base, exponent
  logic [31:0] pres_r, pbase_r, pexp_r;
  logic        pphase_r;
  logic [31:0] res_r;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  assign rem_sh = {rem_r[30:0], x_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, y_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (req.start) st_nxt = (req.kind == AK_POW) ? S_POW : S_RUN;
      S_RUN:  if (cnt_r == 6'd31) st_nxt = S_DONE;
      S_POW:  if (cnt_r == 6'd31 && pphase_r) st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        kind_r   <= req.kind;
        cnt_r    <= '0;
        acc_r    <= '0;
        rem_r    <= '0;
        pphase_r <= 1'b0;
        pres_r   <= 32'd1;
        pbase_r  <= req.a;
        pexp_r   <= req.b;
        if (req.kind == AK_MUL) begin
          x_r <= req.a;
          y_r <= req.b;
          neg_r <= 1'b0;
        end else begin
          x_r <= req.a[31] ? 32'd0 - req.a : req.a;
          y_r <= req.b[31] ? 32'd0 - req.b : req.b;
          neg_r <= (req.kind == AK_DIV) ? (req.a[31] ^ req.b[31]) : req.a[31];
        end
      end
      S_RUN: begin
        cnt_r <= cnt_r + 6'd1;
        if (kind_r == AK_MUL) begin
          if (y_r[0]) acc_r <= acc_r + x_r;
          x_r <= {x_r[30:0], 1'b0};
          y_r <= {1'b0, y_r[31:1]};
        end else begin
          x_r <= {x_r[30:0], 1'b0};
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            acc_r <= {acc_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[30:0], 1'b0};
          end
        end
      end
      S_POW: begin
        // phase 0: result *= base if bit set; phase 1: base *= base
        pphase_r <= ~pphase_r;
        if (!pphase_r) begin
          if (pexp_r[0]) pres_r <= pres_r * pbase_r;
        end else begin
          pbase_r <= pbase_r * pbase_r;
          pexp_r  <= {1'b0, pexp_r[31:1]};
          cnt_r   <= cnt_r + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (kind_r)
      AK_MUL: res_r = acc_r;
      AK_DIV: res_r = neg_r ? 32'd0 - acc_r : acc_r;
      AK_MOD: res_r = neg_r ? 32'd0 - rem_r : rem_r;
      default: begin
        if (pexp_r[31]) res_r = '0;
        else res_r = pres_r;
      end
    endcase
  end

  // negative exponents are settled by the caller
  assign rsp.done = (st_r == S_DONE);
  assign rsp.res  = res_r;

endmodule

### rtl/stack_machine_execute_unit_core.sv
// Stack-machine execute unit. Every accepted instruction gives exactly one
// result transaction. The operand stack and the addressed data store share
// one single-port-write RAM of STACK_DEPTH words; constants sit in a second
// RAM. Each RAM read is registered. The input is taken only in the idle
// state. Push, open, close, branch, nop and setconst pass through decode,
// finish and idle; one-operand operations, write, readin and conditional
// branches pass through issue, top read, execute, finish and idle;
// two-operand operations and store add a second operand read, and load
// adds one extra indirect read. Multiply, divide and modulo run on a
// radix-2 unit; power runs a conditional multiply and a squaring per
// exponent bit. Reserve operations write one word per cycle, except that
// each rsvconst word taken from the constant table first needs a table
// read.
// A result is held in an output register; the next instruction is taken
// while it waits, and a second finished result holds the unit until the
// output register is free.
module stack_machine_execute_unit_core import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_operation,
  input  logic signed [31:0] in_immediate,
  input  logic signed [31:0] in_input_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic        out_out_newline,
  output logic        out_branch_taken,
  output logic signed [31:0] out_branch_label,
  output logic        out_halted,
  output logic [2:0]  out_error_code
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;  // top read issued
  localparam logic [3:0] S_RD2   = 4'd2;  // top word arrives, second read issued
  localparam logic [3:0] S_EXEC  = 4'd3;  // operands available
  localparam logic [3:0] S_IND   = 4'd4;  // indirect word arrives
  localparam logic [3:0] S_ARITH = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;  // reserve sweep
  localparam logic [3:0] S_CRD   = 4'd7;  // constant read wait
  localparam logic [3:0] S_FIN   = 4'd8;  // result ready, wait for output
  localparam logic [3:0] S_OPND  = 4'd9;  // second word arrives

  logic [3:0]  st_r, st_nxt;
  logic [CNTW-1:0] n_r;
  logic        halt_r;
  logic [4:0]  op_r;
  logic [31:0] imm_r, ival_r;
  logic [31:0] a_r, b_r;
  logic [CNTW-1:0] fi_r, fend_r;

  // result holding register
  logic        ov_r, onl_r, tk_r, hl_r;
  logic [31:0] oval_r, lab_r;
  logic [2:0]  err_r;
  logic        res_pend_r;
  logic        take_in, out_free;

  // stack RAM ports
  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [31:0]     s_wdata, s_rdata;
  // constant RAM ports
  logic            c_we;
  logic [CAW-1:0]  c_waddr, c_raddr;
  logic [31:0]     c_rdata;

  smx_ar_req_t ar_req;
  smx_ar_rsp_t ar_rsp;

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  smx_ram #(.WIDTH(32), .DEPTH(CONST_DEPTH)) u_const (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(ival_r),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  smx_arith u_arith (.clk(clk), .rst_n(rst_n), .req(ar_req), .rsp(ar_rsp));

  assign out_free = !res_pend_r || !out_stall;
  assign in_stall = (st_r != S_IDLE);
  assign take_in  = in_valid && (st_r == S_IDLE);

  logic is_unary, is_binary, need1, need2;
  always_comb begin
    is_unary  = (op_r == OP_ABS) || (op_r == OP_NEG) || (op_r == OP_NOT);
    is_binary = (op_r >= OP_ADD) && (op_r <= OP_AND) && !is_unary;
    need2 = is_binary || (op_r == OP_STORE);
    need1 = need2 || is_unary || (op_r == OP_LOAD) || (op_r == OP_READIN) ||
            (op_r == OP_WRITE) || (op_r == OP_WRITELN) ||
            (op_r == OP_BFALSE) || (op_r == OP_BTRUE);
  end

  logic [CNTW-1:0] n_m1, n_m2;
  assign n_m1 = n_r - CNTW'(1);
  assign n_m2 = n_r - CNTW'(2);

  logic a_bad;   // second-from-top (store) or top (load/readin) as address
  logic [31:0] addr_w;
  assign addr_w = (op_r == OP_STORE) ? a_r : b_r;
  assign a_bad  = addr_w >= 32'(STACK_DEPTH);

  function automatic logic lt_s(input logic [31:0] x, input logic [31:0] y);
    lt_s = $signed(x) < $signed(y);
  endfunction

  // combinational next-state / memory control
  logic        fin;
  logic        f_ov, f_nl, f_tk;
  logic [31:0] f_val;
  logic [2:0]  f_err;
  logic [CNTW-1:0] n_nxt;
  logic [32:0] rsv_sum;

  always_comb begin
    st_nxt = st_r;
    n_nxt  = n_r;
    fin    = 1'b0;
    f_ov = 1'b0; f_nl = 1'b0; f_tk = 1'b0; f_val = '0; f_err = ERR_NONE;
    s_we = 1'b0; s_waddr = n_m1[SAW-1:0]; s_wdata = '0;
    s_raddr = n_m1[SAW-1:0];
    c_we = 1'b0; c_waddr = imm_r[CAW-1:0]; c_raddr = fi_r[CAW-1:0];
    ar_req.start = 1'b0; ar_req.a = a_r; ar_req.b = b_r; ar_req.kind = AK_MUL;
    rsv_sum = {1'b0, imm_r} + ((op_r == OP_RSVVAR) ? 33'(n_r) : 33'd0);
    unique case (st_r)
      S_IDLE: if (take_in) st_nxt = S_RD1;
      S_RD1: begin
        // decode; issue top read (address n-1) this cycle
        if (halt_r) begin
          fin = 1'b1;
        end else if (need1 && n_r < CNTW'(need2 ? 2 : 1)) begin
          f_err = ERR_UNF; fin = 1'b1;
        end else if (need1) begin
          st_nxt = S_RD2;
        end else begin
          unique case (op_r)
            OP_OPEN: begin n_nxt = '0; fin = 1'b1; end
            OP_CLOSE: fin = 1'b1;
            OP_PUSH: begin
              if (n_r >= CNTW'(STACK_DEPTH)) f_err = ERR_OVF;
              else begin
                s_we = 1'b1; s_waddr = n_r[SAW-1:0]; s_wdata = imm_r;
                n_nxt = n_r + CNTW'(1);
              end
              fin = 1'b1;
            end
            OP_RSVCONST, OP_RSVVAR: begin
              if (imm_r[31]) begin f_err = ERR_UNF; fin = 1'b1; end
              else if (rsv_sum > 33'(STACK_DEPTH)) begin f_err = ERR_OVF; fin = 1'b1; end
              else st_nxt = S_FILL;
            end
            OP_BRA: begin f_tk = 1'b1; fin = 1'b1; end
            OP_SETCONST: begin
              if (imm_r >= 32'(CONST_DEPTH)) f_err = ERR_ADDR;
              else c_we = 1'b1;
              fin = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_RD2: begin
        s_raddr = n_m2[SAW-1:0];  // b_r captures top
        st_nxt = need2 ? S_OPND : S_EXEC;
      end
      S_OPND: st_nxt = S_EXEC;   // a_r captures second
      S_EXEC: begin
        // b_r = top, a_r = second (when read)
        if (op_r == OP_LOAD || op_r == OP_STORE || op_r == OP_READIN) begin
          if (a_bad) begin f_err = ERR_ADDR; fin = 1'b1; end
          else if (op_r == OP_LOAD) begin
            s_raddr = b_r[SAW-1:0]; st_nxt = S_IND;
          end else if (op_r == OP_STORE) begin
            s_we = 1'b1; s_waddr = a_r[SAW-1:0]; s_wdata = b_r;
            n_nxt = n_m2; fin = 1'b1;
          end else begin
            s_we = 1'b1; s_waddr = b_r[SAW-1:0]; s_wdata = ival_r;
            n_nxt = n_m1; fin = 1'b1;
          end
        end else if (op_r == OP_WRITE || op_r == OP_WRITELN) begin
          f_ov = 1'b1; f_val = b_r; f_nl = (op_r == OP_WRITELN);
          n_nxt = n_m1; fin = 1'b1;
        end else if (op_r == OP_BFALSE || op_r == OP_BTRUE) begin
          f_tk = (op_r == OP_BFALSE) ? (b_r == 32'd0) : (b_r == 32'd1);
          n_nxt = n_m1; fin = 1'b1;
        end else if (is_unary) begin
          s_we = 1'b1;
          unique case (op_r)
            OP_ABS: s_wdata = b_r[31] ? 32'd0 - b_r : b_r;
            OP_NEG: s_wdata = 32'd0 - b_r;
            default: s_wdata = {31'd0, b_r == 32'd0};
          endcase
          fin = 1'b1;
        end else begin
          s_waddr = n_m2[SAW-1:0];
          case (op_r)
            OP_ADD: begin s_we = 1'b1; s_wdata = a_r + b_r; end
            OP_SUB: begin s_we = 1'b1; s_wdata = a_r - b_r; end
            OP_EQ:  begin s_we = 1'b1; s_wdata = {31'd0, a_r == b_r}; end
            OP_NE:  begin s_we = 1'b1; s_wdata = {31'd0, a_r != b_r}; end
            OP_LT:  begin s_we = 1'b1; s_wdata = {31'd0, lt_s(a_r, b_r)}; end
            OP_GT:  begin s_we = 1'b1; s_wdata = {31'd0, lt_s(b_r, a_r)}; end
            OP_LE:  begin s_we = 1'b1; s_wdata = {31'd0, !lt_s(b_r, a_r)}; end
            OP_GE:  begin s_we = 1'b1; s_wdata = {31'd0, !lt_s(a_r, b_r)}; end
            OP_OR:  begin s_we = 1'b1; s_wdata = {31'd0, (a_r != 0) || (b_r != 0)}; end
            OP_AND: begin s_we = 1'b1; s_wdata = {31'd0, (a_r != 0) && (b_r != 0)}; end
            OP_POW: begin
              if (b_r[31]) begin
                s_we = 1'b1;
                if (a_r == 32'd1) s_wdata = 32'd1;
                else if (a_r == 32'hFFFF_FFFF) s_wdata = b_r[0] ? 32'hFFFF_FFFF : 32'd1;
                else s_wdata = '0;
              end else begin
                ar_req.start = 1'b1; ar_req.kind = AK_POW; st_nxt = S_ARITH;
              end
            end
            default: begin
              // mul, div, mod
              if (op_r == OP_DIV && b_r == 32'd0) f_err = ERR_DIV0;
              else if (op_r == OP_MOD && b_r == 32'd0) f_err = ERR_MOD0;
              else begin
                ar_req.start = 1'b1;
                ar_req.kind = (op_r == OP_MUL) ? AK_MUL :
                              (op_r == OP_DIV) ? AK_DIV : AK_MOD;
                st_nxt = S_ARITH;
              end
            end
          endcase
          if (st_nxt != S_ARITH) begin
            if (s_we) n_nxt = n_m1;
            fin = 1'b1;
          end
        end
      end
      S_IND: begin
        s_we = 1'b1; s_wdata = s_rdata; fin = 1'b1;
      end
      S_ARITH: begin
        if (ar_rsp.done) begin
          s_we = 1'b1; s_waddr = n_m2[SAW-1:0]; s_wdata = ar_rsp.res;
          n_nxt = n_m1; fin = 1'b1;
        end
      end
      S_FILL: begin
        // rsvconst: read constant at fi, write next cycle via S_CRD
        if (fi_r == fend_r) begin
          n_nxt = fend_r; fin = 1'b1;
        end else if (op_r == OP_RSVCONST && fi_r < CNTW'(CONST_DEPTH)) begin
          st_nxt = S_CRD;
        end else begin
          s_we = 1'b1; s_waddr = fi_r[SAW-1:0]; s_wdata = '0;
        end
      end
      S_CRD: begin
        s_we = 1'b1; s_waddr = fi_r[SAW-1:0]; s_wdata = c_rdata;
        st_nxt = S_FILL;
      end
      S_FIN: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (fin) st_nxt = S_FIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      n_r <= '0;
      halt_r <= 1'b0;
      res_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      n_r <= n_nxt;
      if (st_r == S_RD1 && !halt_r && op_r == OP_CLOSE) halt_r <= 1'b1;
      // hand the result to the output register only when it is free
      if (st_r == S_FIN && out_free) res_pend_r <= 1'b1;
      else if (res_pend_r && !out_stall) res_pend_r <= 1'b0;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      op_r <= in_operation;
      imm_r <= in_immediate;
      ival_r <= in_input_value;
    end
    if (st_r == S_RD2) begin
      b_r <= s_rdata;
    end
    if (st_r == S_OPND) begin
      a_r <= s_rdata;
    end
    if (st_r == S_RD1) begin
      fi_r <= (op_r == OP_RSVVAR) ? n_r : '0;
      fend_r <= rsv_sum[CNTW-1:0];
    end else if ((st_r == S_FILL && st_nxt == S_FILL && fi_r != fend_r) ||
                 st_r == S_CRD) begin
      fi_r <= fi_r + CNTW'(1);
    end
    if (fin) begin
      ov_r <= f_ov; onl_r <= f_nl; oval_r <= f_val;
      tk_r <= f_tk; lab_r <= f_tk ? imm_r : 32'd0; err_r <= f_err;
      hl_r <= halt_r || (op_r == OP_CLOSE);
    end
  end

  // output register
  logic        po_ov, po_nl, po_tk, po_hl;
  logic [31:0] po_val, po_lab;
  logic [2:0]  po_err;
  always_ff @(posedge clk) begin
    if (st_r == S_FIN && out_free) begin
      po_ov <= ov_r; po_nl <= onl_r; po_val <= oval_r;
      po_tk <= tk_r; po_lab <= lab_r; po_hl <= hl_r; po_err <= err_r;
    end
  end

  assign out_valid        = res_pend_r;
  assign out_out_valid    = po_ov;
  assign out_out_value    = po_val;
  assign out_out_newline  = po_nl;
  assign out_branch_taken = po_tk;
  assign out_branch_label = po_lab;
  assign out_halted       = po_hl;
  assign out_error_code   = po_err;

  a_no_push_past_full: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNTW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag cleared");
  a_no_write_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && st_r == S_RD1) |-> !s_we && !c_we) else $error("write after halt");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && !out_free) |=> st_r == S_FIN) else $error("result dropped");

endmodule
